// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;

  // Field and address widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int LIN_W  = 11;
  localparam int IDX_W  = 11;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;

  // Blank cell: character 0, attribute 7
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;

  // Opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Control characters
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_COPY  = 5'b00100,
    S_BLANK = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/text_console_writer_unit.sv =====
// Put-char, read and unused-opcode items: the item passes through S_PUSH to a registered result;
// no new item is accepted until it is back in S_IDLE, and it holds in S_PUSH while the previous
// result is stalled. Scrolling put-char: a copy pass over all rows but the last, one cell a cycle,
// then a blank pass over the last row; clear: a blank pass over the memory, one cell a cycle.
// Reset: synchronous; cursor homes and a clearing pass blanks the screen, with no item accepted
// until it ends.
module text_console_writer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [7:0]                char_code,
  input  logic [7:0]                attribute,
  input  logic [tcw_pkg::IDX_W-1:0] cell_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcw_pkg::ROW_W-1:0] cursor_row,
  output logic [tcw_pkg::COL_W-1:0] cursor_col,
  output logic [tcw_pkg::LIN_W-1:0] cursor_linear,
  output logic [7:0]                read_char,
  output logic [7:0]                read_attr,
  output logic                      scrolled
);
  import tcw_pkg::*;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   cnt, cnt_next;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic                clr_reply;
  logic                pend_read_ok;
  logic                pend_scrolled;

  logic [CELL_W-1:0]   mem [CELL_COUNT];
  logic [CELL_W-1:0]   rd_data;
  logic                we, re;
  logic [ADDR_W-1:0]   wa, ra;
  logic [CELL_W-1:0]   wd;

  logic                accept;
  logic                is_newline, is_tab;
  logic [COL_W-2:0]    tab_q;
  logic [COL_W:0]      tab_col;
  logic                wrap;
  logic                at_bottom;
  logic [COL_W-1:0]    col_adv;
  logic [LIN_W-1:0]    lin;
  logic                read_ok;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Cursor arithmetic for a put-char item
  assign is_newline = (char_code == CH_LF) || (char_code == CH_CR);
  assign is_tab     = (char_code == CH_TAB);
  assign tab_q      = {1'b0, col[COL_W-1:2]} + 1'b1;
  assign tab_col    = {tab_q, 2'b00};
  assign col_adv    = col + 1'b1;
  assign at_bottom  = (row == ROW_W'(ROWS - 1));
  assign lin        = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  assign read_ok    = (cell_index < IDX_W'(CELL_COUNT));

  always_comb begin
    if (is_newline) begin
      wrap = 1'b1;
    end else if (is_tab) begin
      wrap = (tab_col >= (COL_W + 1)'(COLUMNS));
    end else begin
      wrap = (col == COL_W'(COLUMNS - 1));
    end
  end

  // Sequence the memory accesses; copy reads run one row and one cell ahead of writes,
  // so a cell is always read before it is overwritten
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    we         = 1'b0;
    wa         = cnt;
    wd         = BLANK_CELL;
    re         = 1'b0;
    ra         = ADDR_W'(cell_index);
    case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          case (opcode)
            OP_PUT: begin
              if (!is_newline && !is_tab) begin
                we = 1'b1;
                wa = ADDR_W'(lin);
                wd = {attribute, char_code};
              end
              state_next = (wrap && at_bottom) ? S_COPY : S_PUSH;
            end
            OP_CLEAR: begin
              state_next = S_CLEAR;
            end
            OP_READ: begin
              re         = read_ok;
              state_next = S_PUSH;
            end
            default: begin
              state_next = S_PUSH;
            end
          endcase
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = clr_reply ? S_PUSH : S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_COPY: begin
        re = (cnt != ADDR_W'(MOVE_COUNT));
        ra = cnt + ADDR_W'(COLUMNS);
        we = (cnt != '0);
        wa = cnt - 1'b1;
        wd = rd_data;
        if (cnt == ADDR_W'(MOVE_COUNT)) begin
          state_next = S_BLANK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_BLANK: begin
        we = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = S_PUSH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  // Advance state, cursor and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      row           <= '0;
      col           <= '0;
      clr_reply     <= 1'b0;
      pend_read_ok  <= 1'b0;
      pend_scrolled <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) begin
        pend_read_ok  <= (opcode == OP_READ) && read_ok;
        pend_scrolled <= (opcode == OP_PUT) && wrap && at_bottom;
        clr_reply     <= 1'b1;
        case (opcode)
          OP_PUT: begin
            if (wrap) begin
              col <= '0;
              if (!at_bottom) begin
                row <= row + 1'b1;
              end
            end else if (is_tab) begin
              col <= tab_col[COL_W-1:0];
            end else begin
              col <= col_adv;
            end
          end
          OP_CLEAR: begin
            row <= '0;
            col <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Hold the result until the far side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      cursor_row    <= row;
      cursor_col    <= col;
      cursor_linear <= lin;
      read_char     <= pend_read_ok ? rd_data[7:0] : 8'd0;
      read_attr     <= pend_read_ok ? rd_data[15:8] : 8'd0;
      scrolled      <= pend_scrolled;
    end
  end

endmodule

// ===== rtl/core/tcw_checker.sv =====
`include "assert_macros.svh"

module tcw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                opcode,
  input logic [7:0]                char_code,
  input logic [7:0]                attribute,
  input logic [tcw_pkg::IDX_W-1:0] cell_index,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [tcw_pkg::ROW_W-1:0] cursor_row,
  input logic [tcw_pkg::COL_W-1:0] cursor_col,
  input logic [tcw_pkg::LIN_W-1:0] cursor_linear,
  input logic [7:0]                read_char,
  input logic [7:0]                read_attr,
  input logic                      scrolled
);
  import tcw_pkg::*;

  // Stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cursor_linear) && $stable(read_char) && $stable(read_attr) && $stable(scrolled), "result changed while stalled")

  // Cursor stays on screen
  `TCW_ASSERT(a_cursor_range, out_valid |-> (cursor_row < ROW_W'(ROWS)) && (cursor_col < COL_W'(COLUMNS)), "cursor off screen")

  // Linear cursor matches row and column
  `TCW_ASSERT(a_cursor_linear, out_valid |-> (cursor_linear == LIN_W'(cursor_row) * LIN_W'(COLUMNS) + LIN_W'(cursor_col)), "linear cursor mismatch")

  // A scroll leaves the cursor at the start of the last row
  `TCW_ASSERT(a_scroll_cursor, (out_valid && scrolled) |-> (cursor_row == ROW_W'(ROWS - 1)) && (cursor_col == '0), "scroll left cursor misplaced")

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);
